/* rtl/core/median_of_two_sorted_arrays_defines.svh */
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays_defines.svh
// Assertion macros shared by the median block.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_DEFINES_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define MSA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define MSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/msa_pkg.sv */
// ----------------------------------------------------------------------------
// msa_pkg
// Opcodes, status codes, fixed field widths and queue types.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int OUT_W    = 33;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR         = 2'd0,
    OP_APPEND_FIRST  = 2'd1,
    OP_APPEND_SECOND = 2'd2,
    OP_MEDIAN        = 2'd3
  } opcode_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_PART  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e_t;

  // Queue condition seen by the front and back.
  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

endpackage

/* rtl/core/median_of_two_sorted_arrays.sv */
// Clear and append transactions retire one per cycle once queued.
// Median: the result passes the input register, the queue pop, up to
// ceil(log2(min(n1, n2) + 2)) probe/compare pairs and the output register; a probe
// that finds no partition ends the search without its compare, and an empty or
// overflowed median skips the search. Result stalls hold it in DONE. One median is in flight at a time.
// Reset clears counts, overflow flag, queue and output valid; stores are not cleared.
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays
// Two sorted word stores fed by append transactions; a median transaction
// returns twice the median of the combined contents plus a status code.
// ----------------------------------------------------------------------------
module median_of_two_sorted_arrays #(
  parameter int MAX_LEN    = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Command channel.
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [msa_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [msa_pkg::VALUE_W-1:0] value,
  // Result channel.
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [msa_pkg::OUT_W-1:0]   twice_median,
  output logic [msa_pkg::STATUS_W-1:0]       status
);
  import msa_pkg::*;

  localparam int QW = OPCODE_W + WORD_WIDTH;

  // Front -> queue -> back. The queue decouples the search, which keeps the
  // back busy, from the command channel.
  q_status_t     q_stat;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;

  // Front: registers the command transaction and trims the value.
  msa_front #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .opcode    (opcode),
    .value     (value),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  msa_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // Back: stores, counts, partition search and the output register.
  msa_back #(
    .MAX_LEN    (MAX_LEN),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .twice_median (twice_median),
    .status       (status)
  );

endmodule

/* rtl/core/msa_front.sv */
// ----------------------------------------------------------------------------
// msa_front
// Input stage: registers a transaction, decodes the opcode and trims the
// value to the stored word width, then hands it to the queue.
// ----------------------------------------------------------------------------
module msa_front #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cmd_valid,
  output logic                                      cmd_stall,
  input  logic [msa_pkg::OPCODE_W-1:0]              opcode,
  input  logic signed [msa_pkg::VALUE_W-1:0]        value,
  input  msa_pkg::q_status_t                        q_stat,
  output logic                                      q_push,
  output logic [msa_pkg::OPCODE_W+WORD_WIDTH-1:0]   q_data
);
  import msa_pkg::*;

  logic                  held;
  opcode_e_t             held_op;
  logic [WORD_WIDTH-1:0] held_word;
  logic                  accept;

  assign q_push    = held && !q_stat.full;
  assign cmd_stall = held && q_stat.full;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_data    = {held_op, held_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  // Only the low word bits are kept; appends read them as two's complement.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_op   <= opcode_e_t'(opcode);
      held_word <= value[WORD_WIDTH-1:0];
    end
  end

endmodule

/* rtl/core/msa_queue.sv */
// ----------------------------------------------------------------------------
// msa_queue
// Short FIFO between front and back; lets each side stall on its own.
// ----------------------------------------------------------------------------
module msa_queue #(
  parameter int DW = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [DW-1:0]      push_data,
  input  logic               pop,
  output logic [DW-1:0]      pop_data,
  output msa_pkg::q_status_t stat
);
  import msa_pkg::*;

  logic [DW-1:0]     slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign stat.avail = (fill != '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.avail;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/msa_back.sv */
// ----------------------------------------------------------------------------
// msa_back
// Execution side: the two word stores, their counts, and the partition
// search that produces twice the median.
// ----------------------------------------------------------------------------
`include "median_of_two_sorted_arrays_defines.svh"

module msa_back #(
  parameter int MAX_LEN    = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  msa_pkg::q_status_t                      q_stat,
  input  logic [msa_pkg::OPCODE_W+WORD_WIDTH-1:0] q_data,
  output logic                                    q_pop,
  output logic                                    res_valid,
  input  logic                                    res_stall,
  output logic signed [msa_pkg::OUT_W-1:0]        twice_median,
  output logic [msa_pkg::STATUS_W-1:0]            status
);
  import msa_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int IW = CW + 2;

  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    PROBE = 4'b0010,
    EVAL  = 4'b0100,
    DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  opcode_e_t             q_op;
  logic [WORD_WIDTH-1:0] q_word;

  logic [WORD_WIDTH-1:0] mem_first  [MAX_LEN];
  logic [WORD_WIDTH-1:0] mem_second [MAX_LEN];
  logic signed [WORD_WIDTH-1:0] rd_first0, rd_first1, rd_second0, rd_second1;
  logic [AW-1:0] addr_first0, addr_first1, addr_second0, addr_second1;

  logic [CW-1:0] count_first, count_second;
  logic          overflow_seen;
  logic          full_first, full_second;
  logic          wr_first, wr_second;

  // Search registers.
  logic                  swap;
  logic [CW-1:0]         short_n, long_n;
  logic signed [IW-1:0]  half, lo, hi;
  logic                  odd;
  logic [CW-1:0]         ca_r, cb_r;
  logic signed [WORD_WIDTH-1:0] left, right;
  status_e_t             st;

  // Median setup.
  logic          med_start, med_trivial;
  logic [CW:0]   total;

  // Probe step.
  logic signed [IW-1:0] diff, ca_c, cb_c;
  logic [CW-1:0]        ca_u, cb_u;
  logic                 range_bad;
  logic [AW-1:0]        short_a0, short_a1, long_a0, long_a1;

  // Evaluate step.
  logic signed [WORD_WIDTH-1:0] sa0, sa1, lb0, lb1, la, ra, lb, rb;
  logic                         fit;

  // Result.
  logic                       load_out;
  logic signed [WORD_WIDTH:0] sum_c;

  assign q_op   = opcode_e_t'(q_data[OPCODE_W+WORD_WIDTH-1 -: OPCODE_W]);
  assign q_word = q_data[WORD_WIDTH-1:0];
  assign q_pop  = (state == IDLE) && q_stat.avail;

  assign full_first  = (count_first == CW'(MAX_LEN));
  assign full_second = (count_second == CW'(MAX_LEN));
  assign wr_first    = q_pop && (q_op == OP_APPEND_FIRST) && !full_first;
  assign wr_second   = q_pop && (q_op == OP_APPEND_SECOND) && !full_second;

  assign med_start   = q_pop && (q_op == OP_MEDIAN);
  assign med_trivial = overflow_seen || ((count_first == '0) && (count_second == '0));
  assign total       = {1'b0, count_first} + {1'b0, count_second};

  // Next cut point of the shorter store and its partner in the longer one.
  always_comb begin
    diff      = hi - lo;
    ca_c      = lo + (diff >>> 1);
    cb_c      = half - ca_c;
    ca_u      = ca_c[CW-1:0];
    cb_u      = cb_c[CW-1:0];
    range_bad = (lo > hi) || (cb_c < 0) || (cb_c > $signed({2'b00, long_n}));
    short_a0  = (ca_u == '0) ? '0 : AW'(ca_u - 1'b1);
    short_a1  = (ca_u == short_n) ? '0 : ca_u[AW-1:0];
    long_a0   = (cb_u == '0) ? '0 : AW'(cb_u - 1'b1);
    long_a1   = (cb_u == long_n) ? '0 : cb_u[AW-1:0];
  end

  always_comb begin
    if (swap) begin
      addr_first0  = long_a0;
      addr_first1  = long_a1;
      addr_second0 = short_a0;
      addr_second1 = short_a1;
    end else begin
      addr_first0  = short_a0;
      addr_first1  = short_a1;
      addr_second0 = long_a0;
      addr_second1 = long_a1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      mem_first[count_first[AW-1:0]] <= q_word;
    end
    if (wr_second) begin
      mem_second[count_second[AW-1:0]] <= q_word;
    end
    rd_first0  <= mem_first[addr_first0];
    rd_first1  <= mem_first[addr_first1];
    rd_second0 <= mem_second[addr_second0];
    rd_second1 <= mem_second[addr_second1];
  end

  // Missing neighbors at the ends stand for the extreme words.
  always_comb begin
    sa0 = swap ? rd_second0 : rd_first0;
    sa1 = swap ? rd_second1 : rd_first1;
    lb0 = swap ? rd_first0 : rd_second0;
    lb1 = swap ? rd_first1 : rd_second1;
    la  = (ca_r == '0) ? WORD_MIN : sa0;
    ra  = (ca_r == short_n) ? WORD_MAX : sa1;
    lb  = (cb_r == '0) ? WORD_MIN : lb0;
    rb  = (cb_r == long_n) ? WORD_MAX : lb1;
    fit = (la <= rb) && (lb <= ra);
  end

  assign load_out = (state == DONE) && (!res_valid || !res_stall);
  assign sum_c    = odd ? {right, 1'b0}
                        : ({left[WORD_WIDTH-1], left} + {right[WORD_WIDTH-1], right});

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (med_start) begin
          state_next = med_trivial ? DONE : PROBE;
        end
      end
      PROBE: state_next = range_bad ? DONE : EVAL;
      EVAL:  state_next = fit ? DONE : PROBE;
      DONE: begin
        if (load_out) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count_first   <= '0;
      count_second  <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        unique case (q_op)
          OP_CLEAR: begin
            count_first   <= '0;
            count_second  <= '0;
            overflow_seen <= 1'b0;
          end
          OP_APPEND_FIRST: begin
            if (full_first) begin
              overflow_seen <= 1'b1;
            end else begin
              count_first <= count_first + 1'b1;
            end
          end
          OP_APPEND_SECOND: begin
            if (full_second) begin
              overflow_seen <= 1'b1;
            end else begin
              count_second <= count_second + 1'b1;
            end
          end
          OP_MEDIAN: begin
          end
          default: begin
          end
        endcase
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (med_start) begin
      // Equal lengths search the first store.
      swap    <= (count_first > count_second);
      short_n <= (count_first > count_second) ? count_second : count_first;
      long_n  <= (count_first > count_second) ? count_first : count_second;
      half    <= IW'(total >> 1);
      odd     <= total[0];
      lo      <= '0;
      hi      <= IW'((count_first > count_second) ? count_second : count_first);
      st      <= overflow_seen ? ST_OVERFLOW : ST_EMPTY;
    end
    if (state == PROBE) begin
      ca_r <= ca_u;
      cb_r <= cb_u;
      if (range_bad) begin
        st <= ST_NO_PART;
      end
    end
    if (state == EVAL) begin
      if (fit) begin
        left  <= (la > lb) ? la : lb;
        right <= (ra < rb) ? ra : rb;
        st    <= ST_OK;
      end else if (la > rb) begin
        hi <= $signed({2'b00, ca_r}) - IW'(1);
      end else begin
        lo <= $signed({2'b00, ca_r}) + IW'(1);
      end
    end
    if (load_out) begin
      status       <= st;
      twice_median <= (st == ST_OK) ? OUT_W'(sum_c) : '0;
    end
  end

  `MSA_ASSERT_ALWAYS(a_count_bound, clk, rst, (count_first <= CW'(MAX_LEN)) && (count_second <= CW'(MAX_LEN)), "store count above capacity")
  `MSA_ASSERT_IMPLY(a_cut_bound, clk, rst, state == EVAL, (ca_r <= short_n) && (cb_r <= long_n), "cut point outside its store")
  `MSA_ASSERT_IMPLY(a_error_zero, clk, rst, res_valid && (status != ST_OK), twice_median == '0, "nonzero result with error status")
  `MSA_ASSERT_NEXT(a_drop_flag, clk, rst, q_pop && (q_op == OP_APPEND_FIRST) && full_first, overflow_seen, "dropped append not flagged")
  `MSA_ASSERT_NEXT(a_done_emits, clk, rst, (state == DONE) && !res_valid, res_valid, "finished median not presented")

endmodule
